[hw/rtl/thi_pkg.sv]
// Package for the terrain height interpolator: grid sizes, register indexes,
// request and response word types. Depends on nothing.
package thi_pkg;

   localparam int GRID_POINTS = 128;
   localparam int CELL_W      = $clog2(GRID_POINTS);
   localparam int HALF_POINTS = (GRID_POINTS + 1) / 2;
   localparam int BANK_DEPTH  = HALF_POINTS * HALF_POINTS;
   localparam int BANK_AW     = $clog2(BANK_DEPTH);
   localparam int FRAC_ONE    = 65536;

   localparam logic [1:0] CSR_ORIGIN_X   = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y   = 2'd1;
   localparam logic [1:0] CSR_CELL_SCALE = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [6:0]         grid_col;
      logic [6:0]         grid_row;
      logic signed [15:0] vertex_height;
      logic signed [23:0] world_x;
      logic signed [23:0] world_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] ground_height;
      logic               outside;
   } rsp_type;

endpackage

[hw/rtl/terrain_height_interpolator.sv]
// Terrain height interpolator top level: six-stage pipeline around four
// parity-banked grid memories. Depends on thi_pkg and thi_bank_ram.
//
// Usage: raise start with a word on req_word; it is taken at that edge since
// busy stays low, so one word may enter every cycle. A write word stores one
// grid height and gives no response. A query word gives exactly one response
// word on rsp_word, with rsp_strobe high for one cycle. The strobe and the
// response word are registered together in the last stage. Throughput is one
// word per cycle: the grid is split into four banks by column and row parity,
// so the four corners of a cell are read together, one per bank port. Words
// stay in order, so a query sees every write taken before it. Registers
// origin_x, origin_y and cell_scale are written through csr_we, csr_index and
// csr_wdata; the user must write them only while no query is in flight, the
// block does not enforce this. Synchronous reset clears the pipeline and sets
// the registers to their defaults; grid contents are undefined until written.
// The receiver cannot stall: each response is present for one cycle only.
module terrain_height_interpolator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  thi_pkg::req_type req_word,
   output logic             rsp_strobe,
   output thi_pkg::rsp_type rsp_word,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [23:0]      csr_wdata
);
   import thi_pkg::*;

   logic        [23:0] origin_x_ff, origin_y_ff, cell_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= 24'd0;
         origin_y_ff   <= 24'd0;
         cell_scale_ff <= 24'd65536;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X:   origin_x_ff   <= csr_wdata;
            CSR_ORIGIN_Y:   origin_y_ff   <= csr_wdata;
            CSR_CELL_SCALE: cell_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   logic accept;
   assign accept = start && !busy;

   // stage 1: offsets
   logic               s1_valid_ff, s1_op_ff;
   logic signed [24:0] s1_tx_ff, s1_ty_ff, s1_tx_in, s1_ty_in;
   logic [6:0]         s1_col_ff, s1_row_ff;
   logic [15:0]        s1_h_ff;

   assign s1_tx_in = 25'(req_word.world_x) - 25'(signed'(origin_x_ff));
   assign s1_ty_in = 25'(req_word.world_y) - 25'(signed'(origin_y_ff));

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= accept;
      s1_op_ff  <= req_word.operation;
      s1_tx_ff  <= s1_tx_in;
      s1_ty_ff  <= s1_ty_in;
      s1_col_ff <= req_word.grid_col;
      s1_row_ff <= req_word.grid_row;
      s1_h_ff   <= req_word.vertex_height;
   end

   // stage 2: scale to grid units
   logic        s2_valid_ff, s2_op_ff, s2_negx_ff, s2_negy_ff;
   logic [47:0] s2_gx_ff, s2_gy_ff;
   logic [6:0]  s2_col_ff, s2_row_ff;
   logic [15:0] s2_h_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_op_ff   <= s1_op_ff;
      s2_negx_ff <= s1_tx_ff[24];
      s2_negy_ff <= s1_ty_ff[24];
      s2_gx_ff   <= s1_tx_ff[23:0] * cell_scale_ff;
      s2_gy_ff   <= s1_ty_ff[23:0] * cell_scale_ff;
      s2_col_ff  <= s1_col_ff;
      s2_row_ff  <= s1_row_ff;
      s2_h_ff    <= s1_h_ff;
   end

   // stage 2 logic: cell select, bank access
   logic              out_x, out_y, s2_out;
   logic [CELL_W-1:0] cx, cy, cx1, cy1;
   logic              wr_ok;
   logic [CELL_W-1:0] wcol, wrow;
   logic [BANK_AW-1:0] waddr;
   logic [BANK_AW-1:0] bank_addr [4];
   logic               bank_we   [4];
   logic [15:0]        bank_rdata [4];

   assign out_x = s2_negx_ff || (s2_gx_ff[47:24] >= 24'(GRID_POINTS - 1));
   assign out_y = s2_negy_ff || (s2_gy_ff[47:24] >= 24'(GRID_POINTS - 1));
   assign s2_out = out_x || out_y;
   assign cx  = s2_gx_ff[24+CELL_W-1:24];
   assign cy  = s2_gy_ff[24+CELL_W-1:24];
   assign cx1 = cx + 1'b1;
   assign cy1 = cy + 1'b1;

   assign wr_ok = (32'(s2_col_ff) < 32'(GRID_POINTS)) && (32'(s2_row_ff) < 32'(GRID_POINTS));
   assign wcol  = CELL_W'(s2_col_ff);
   assign wrow  = CELL_W'(s2_row_ff);
   assign waddr = BANK_AW'(32'(wrow >> 1) * HALF_POINTS + 32'(wcol >> 1));

   // bank index is {row parity, column parity}
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [CELL_W-1:0] rcol, rrow;
      assign rcol = (cx[0] == b[0]) ? cx : cx1;
      assign rrow = (cy[0] == b[1]) ? cy : cy1;
      assign bank_we[b] = s2_valid_ff && (s2_op_ff == OP_WRITE) && wr_ok &&
                          (wcol[0] == b[0]) && (wrow[0] == b[1]);
      assign bank_addr[b] = (s2_op_ff == OP_WRITE) ? waddr :
         BANK_AW'(32'(rrow >> 1) * HALF_POINTS + 32'(rcol >> 1));
      thi_bank_ram #(.DEPTH(BANK_DEPTH), .WIDTH(16)) u_bank (
         .clock (clock),
         .we    (bank_we[b]),
         .addr  (bank_addr[b]),
         .wdata (s2_h_ff),
         .rdata (bank_rdata[b])
      );
   end

   // stage 3: corner heights arrive
   logic        s3_valid_ff, s3_out_ff, s3_px_ff, s3_py_ff;
   logic [15:0] s3_fx_ff, s3_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff && (s2_op_ff == OP_QUERY);
      s3_out_ff <= s2_out;
      s3_px_ff  <= cx[0];
      s3_py_ff  <= cy[0];
      s3_fx_ff  <= s2_gx_ff[23:8];
      s3_fy_ff  <= s2_gy_ff[23:8];
   end

   logic [15:0] h00, h10, h01, h11;
   logic [17:0] fsum;
   logic        upper;
   logic [16:0] w0_in, w1_in, w2_in;
   logic [15:0] ha_in, hb_in, hc_in;

   assign h00 = bank_rdata[{s3_py_ff, s3_px_ff}];
   assign h10 = bank_rdata[{s3_py_ff, ~s3_px_ff}];
   assign h01 = bank_rdata[{~s3_py_ff, s3_px_ff}];
   assign h11 = bank_rdata[{~s3_py_ff, ~s3_px_ff}];
   assign fsum  = 18'(s3_fx_ff) + 18'(s3_fy_ff);
   assign upper = fsum <= 18'(FRAC_ONE);

   always_comb begin
      if (upper) begin
         w0_in = 17'(18'(FRAC_ONE) - fsum);
         w1_in = 17'(s3_fx_ff);
         w2_in = 17'(s3_fy_ff);
         ha_in = h00;
         hb_in = h10;
         hc_in = h01;
      end else begin
         w0_in = 17'(18'(FRAC_ONE) - 18'(s3_fy_ff));
         w1_in = 17'(fsum - 18'(FRAC_ONE));
         w2_in = 17'(18'(FRAC_ONE) - 18'(s3_fx_ff));
         ha_in = h10;
         hb_in = h11;
         hc_in = h01;
      end
   end

   // stage 4: weights and heights
   logic        s4_valid_ff, s4_out_ff;
   logic [16:0] s4_w0_ff, s4_w1_ff, s4_w2_ff;
   logic signed [15:0] s4_ha_ff, s4_hb_ff, s4_hc_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else       s4_valid_ff <= s3_valid_ff;
      s4_out_ff <= s3_out_ff;
      s4_w0_ff  <= w0_in;
      s4_w1_ff  <= w1_in;
      s4_w2_ff  <= w2_in;
      s4_ha_ff  <= ha_in;
      s4_hb_ff  <= hb_in;
      s4_hc_ff  <= hc_in;
   end

   // stage 5: products
   logic               s5_valid_ff, s5_out_ff;
   logic signed [33:0] s5_p0_ff, s5_p1_ff, s5_p2_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else       s5_valid_ff <= s4_valid_ff;
      s5_out_ff <= s4_out_ff;
      s5_p0_ff  <= 34'($signed({1'b0, s4_w0_ff}) * s4_ha_ff);
      s5_p1_ff  <= 34'($signed({1'b0, s4_w1_ff}) * s4_hb_ff);
      s5_p2_ff  <= 34'($signed({1'b0, s4_w2_ff}) * s4_hc_ff);
   end

   // stage 6: sum, round half up, drive response
   logic signed [35:0] acc;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff, rsp_in;

   assign acc = 36'(s5_p0_ff) + 36'(s5_p1_ff) + 36'(s5_p2_ff) + 36'sd32768;

   always_comb begin
      rsp_in.outside       = s5_out_ff;
      rsp_in.ground_height = s5_out_ff ? 16'sd0 : acc[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= s5_valid_ff;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

`ifndef ASSERT_OFF
   a_query_answers: assert property (@(posedge clock) disable iff (reset)
      accept && (req_word.operation == OP_QUERY) |-> ##6 rsp_strobe)
      else $error("query word lost in pipeline");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      accept && (req_word.operation == OP_WRITE) |-> ##6 !rsp_strobe)
      else $error("write word produced a response");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.outside |-> rsp_word.ground_height == 16'sd0)
      else $error("outside response carries a height");

   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({bank_we[3], bank_we[2], bank_we[1], bank_we[0]}))
      else $error("more than one bank written");
`endif

endmodule

[hw/rtl/thi_bank_ram.sv]
// One bank of the height grid: single port, write or read per cycle,
// registered read data. Depends on nothing.
module thi_bank_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
